// File: design/lobm_pkg.sv
// Package: order book constants, opcodes, result kinds and controller states.
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;
	localparam int ORDER_SLOTS = 64;
	localparam int PRICE_BITS  = 16;
	localparam int SLOT_BITS   = $clog2(ORDER_SLOTS);
	localparam int ID_BITS     = 31;
	localparam int QTY_BITS    = 31;
	localparam int ARR_BITS    = 32;
	localparam int COUNT_BITS  = 7;
	localparam int MAX_FILLS   = 64;
	localparam int FILL_BITS   = $clog2(MAX_FILLS + 1);

	localparam logic [2:0] OP_ADD_NEW   = 3'd0;
	localparam logic [2:0] OP_ADD_GIVEN = 3'd1;
	localparam logic [2:0] OP_CANCEL    = 3'd2;
	localparam logic [2:0] OP_MODIFY    = 3'd3;
	localparam logic [2:0] OP_MATCH     = 3'd4;

	localparam logic [2:0] K_ACCEPTED  = 3'd0;
	localparam logic [2:0] K_FILL      = 3'd1;
	localparam logic [2:0] K_NOT_FOUND = 3'd2;
	localparam logic [2:0] K_FULL      = 3'd3;
	localparam logic [2:0] K_NO_CROSS  = 3'd4;

	localparam logic CFG_BASE_ID = 1'b0;
	localparam logic CFG_INIT_COUNT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_TAIL,
		ST_DECIDE,
		ST_RD_A,
		ST_RD_B,
		ST_APPLY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
		logic [ID_BITS-1:0]    id;
		logic [ARR_BITS-1:0]   arrival;
		logic                  side;
	} slot_t;
endpackage
`default_nettype wire

// File: design/limit_order_book_matcher_top.sv
// Top level: order book matcher with slot memory and scanning sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Orders live in a 64-entry slot memory (one read, one write port, registered
// read) with valid bits in flip-flops. Every valid operation scans all slots,
// one per cycle: add, cancel, modify and a match with nothing to cross then
// give their result from the decide state, and the next order is taken in the
// cycle after the result beat at the earliest. A match reads the ask and the
// bid and writes both back for each fill (RD_A, RD_B, APPLY) and then scans
// again to learn whether that fill is the last, so each fill result waits on
// that rescan; the input is held off until the last result beat of an
// operation has been taken.
module limit_order_book_matcher_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [2:0]                      opcode,
	input  wire logic [lobm_pkg::ID_BITS-1:0]    order_id,
	input  wire logic                            side,
	input  wire logic [lobm_pkg::PRICE_BITS-1:0] price,
	input  wire logic [lobm_pkg::QTY_BITS-1:0]   quantity,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [2:0]                           kind,
	output logic [lobm_pkg::ID_BITS-1:0]         result_id,
	output logic [lobm_pkg::ID_BITS-1:0]         buy_id,
	output logic [lobm_pkg::ID_BITS-1:0]         sell_id,
	output logic [lobm_pkg::PRICE_BITS-1:0]      fill_price,
	output logic [lobm_pkg::QTY_BITS-1:0]        fill_quantity,
	output logic [lobm_pkg::COUNT_BITS-1:0]      live_orders,
	output logic                                 last,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [30:0]                     cfg_data
);
	import lobm_pkg::*;

	slot_t mem [ORDER_SLOTS];
	logic [ORDER_SLOTS-1:0] valid_q;
	slot_t rd_data_s1;
	logic [SLOT_BITS-1:0] rd_addr;
	logic rd_en;
	logic we;
	logic [SLOT_BITS-1:0] wr_addr;
	slot_t wr_data;

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_s1 <= mem[rd_addr];
		if (we) mem[wr_addr] <= wr_data;
	end

	state_t state_q, state_d;
	logic [2:0] op_q;
	logic [ID_BITS-1:0] oid_q;
	logic side_in_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [QTY_BITS-1:0] qty_q;
	logic [ID_BITS-1:0] next_id_q, key_id;
	logic [COUNT_BITS-1:0] count_q;
	logic [ARR_BITS-1:0] arr_q;
	logic [SLOT_BITS:0] scan_q;
	logic [SLOT_BITS-1:0] scan_idx_s1;
	logic scan_vld_s1;
	logic [FILL_BITS-1:0] nfill_q;
	logic pend_q;
	logic hit_side_q;

	// scan results
	logic hit_q, free_f_q, ask_f_q, bid_f_q;
	logic [SLOT_BITS-1:0] hit_idx_q, free_idx_q, ask_idx_q, bid_idx_q;
	logic [PRICE_BITS-1:0] ask_p_q, bid_p_q;
	logic [ARR_BITS-1:0] ask_age_q, bid_age_q;
	slot_t a_q;

	assign key_id = (op_q == OP_ADD_NEW) ? next_id_q + 1'b1 : oid_q;

	logic is_match;
	assign is_match = (op_q == OP_MATCH);
	logic [ARR_BITS-1:0] age;
	assign age = arr_q - rd_data_s1.arrival;
	logic crossing;
	assign crossing = is_match && ask_f_q && bid_f_q && bid_p_q >= ask_p_q &&
		nfill_q != FILL_BITS'(MAX_FILLS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && opcode <= OP_MATCH) state_d = ST_SCAN;
			ST_SCAN: if (scan_q == (SLOT_BITS+1)'(ORDER_SLOTS - 1)) state_d = ST_SCAN_TAIL;
			ST_SCAN_TAIL: state_d = ST_DECIDE;
			ST_DECIDE: state_d = (!pend_q && crossing) ? ST_RD_A : ST_OUT;
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_APPLY;
			ST_APPLY: state_d = ST_SCAN;
			ST_OUT: if (out_ready) state_d = last ? ST_IDLE : ST_RD_A;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		rd_en = 1'b0;
		rd_addr = scan_q[SLOT_BITS-1:0];
		case (state_q)
			ST_SCAN: rd_en = 1'b1;
			ST_DECIDE: begin
				rd_en = 1'b1;
				rd_addr = ask_idx_q;
			end
			ST_RD_A: begin
				rd_en = 1'b1;
				rd_addr = bid_idx_q;
			end
			default: ;
		endcase
	end

	// write port and bookkeeping; ask written back in RD_B, bid in APPLY
	logic [QTY_BITS-1:0] fq;
	assign fq = (a_q.qty < rd_data_s1.qty) ? a_q.qty : rd_data_s1.qty;

	always_comb begin
		we = 1'b0;
		wr_addr = hit_q ? hit_idx_q : free_idx_q;
		wr_data = '{price: price_q, qty: qty_q, id: key_id, arrival: arr_q,
			side: (op_q == OP_MODIFY) ? hit_side_q : side_in_q};
		if (state_q == ST_DECIDE && !is_match && op_q != OP_CANCEL)
			we = (op_q == OP_MODIFY) ? hit_q : (hit_q || free_f_q);
		if (state_q == ST_RD_B) begin
			we = 1'b1;
			wr_addr = ask_idx_q;
			wr_data = a_q;
			wr_data.qty = a_q.qty - fq;
		end
		if (state_q == ST_APPLY) begin
			we = 1'b1;
			wr_addr = bid_idx_q;
			wr_data = rd_data_s1;
			wr_data.qty = rd_data_s1.qty - fq;
		end
	end

	logic [COUNT_BITS-1:0] cnt_dn;
	assign cnt_dn = (count_q != '0) ? count_q - 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			next_id_q <= '0;
			count_q <= '0;
			arr_q <= '0;
			out_valid <= 1'b0;
			scan_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_vld_s1 <= (state_q == ST_SCAN);
			if (cfg_we) begin
				if (cfg_index == CFG_BASE_ID) next_id_q <= cfg_data;
				else count_q <= cfg_data[COUNT_BITS-1:0];
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_DECIDE: begin
					if (state_d == ST_OUT) begin
						out_valid <= 1'b1;
						if (!is_match && op_q != OP_CANCEL && we) begin
							valid_q[wr_addr] <= 1'b1;
							arr_q <= arr_q + 1'b1;
							if (op_q == OP_ADD_NEW) begin
								next_id_q <= key_id;
								if (count_q != 7'd127) count_q <= count_q + 1'b1;
							end
						end
						if (op_q == OP_CANCEL && hit_q) begin
							valid_q[hit_idx_q] <= 1'b0;
							count_q <= cnt_dn;
						end
					end
				end
				ST_APPLY: begin
					if (rd_data_s1.qty == fq) valid_q[bid_idx_q] <= 1'b0;
					if (a_q.qty == fq) valid_q[ask_idx_q] <= 1'b0;
					if (rd_data_s1.qty == fq && a_q.qty == fq)
						count_q <= (count_q > 7'd1) ? count_q - 7'd2 : '0;
					else if (rd_data_s1.qty == fq || a_q.qty == fq)
						count_q <= cnt_dn;
				end
				default: ;
			endcase
		end
	end

	// payload and scan registers; a fill is held until the rescan sets last
	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_q[SLOT_BITS-1:0];
		case (state_q)
			ST_IDLE: begin
				op_q <= opcode;
				oid_q <= order_id;
				side_in_q <= side;
				price_q <= price;
				qty_q <= quantity;
				nfill_q <= '0;
				pend_q <= 1'b0;
				scan_q <= '0;
				hit_q <= 1'b0;
				free_f_q <= 1'b0;
				ask_f_q <= 1'b0;
				bid_f_q <= 1'b0;
			end
			ST_SCAN: scan_q <= scan_q + 1'b1;
			ST_RD_A: a_q <= rd_data_s1;
			ST_APPLY: begin
				scan_q <= '0;
				hit_q <= 1'b0;
				free_f_q <= 1'b0;
				ask_f_q <= 1'b0;
				bid_f_q <= 1'b0;
				nfill_q <= nfill_q + 1'b1;
				pend_q <= 1'b1;
				kind <= K_FILL;
				result_id <= '0;
				buy_id <= rd_data_s1.id;
				sell_id <= a_q.id;
				fill_price <= a_q.price;
				fill_quantity <= fq;
			end
			ST_DECIDE: begin
				if (pend_q) begin
					last <= !crossing;
				end else begin
					buy_id <= '0;
					sell_id <= '0;
					fill_price <= '0;
					fill_quantity <= '0;
					last <= 1'b1;
					if (is_match) begin
						kind <= K_NO_CROSS;
						result_id <= '0;
					end else if (op_q == OP_CANCEL || op_q == OP_MODIFY) begin
						kind <= hit_q ? K_ACCEPTED : K_NOT_FOUND;
						result_id <= oid_q;
					end else begin
						kind <= (hit_q || free_f_q) ? K_ACCEPTED : K_FULL;
						result_id <= (hit_q || free_f_q) ? key_id :
							(op_q == OP_ADD_GIVEN ? oid_q : '0);
					end
				end
			end
			default: ;
		endcase
		if (scan_vld_s1 && valid_q[scan_idx_s1]) begin
			if (!hit_q && rd_data_s1.id == key_id) begin
				hit_q <= 1'b1;
				hit_idx_q <= scan_idx_s1;
			end
			if (rd_data_s1.side) begin
				if (!ask_f_q || rd_data_s1.price < ask_p_q ||
					(rd_data_s1.price == ask_p_q && age > ask_age_q)) begin
					ask_f_q <= 1'b1;
					ask_idx_q <= scan_idx_s1;
					ask_p_q <= rd_data_s1.price;
					ask_age_q <= age;
				end
			end else if (!bid_f_q || rd_data_s1.price > bid_p_q ||
				(rd_data_s1.price == bid_p_q && age > bid_age_q)) begin
				bid_f_q <= 1'b1;
				bid_idx_q <= scan_idx_s1;
				bid_p_q <= rd_data_s1.price;
				bid_age_q <= age;
			end
		end
		if (scan_vld_s1 && !valid_q[scan_idx_s1] && !free_f_q) begin
			free_f_q <= 1'b1;
			free_idx_q <= scan_idx_s1;
		end
	end

	// modify keeps the stored side: captured during the scan
	always_ff @(posedge clk) begin
		if (scan_vld_s1 && valid_q[scan_idx_s1] && !hit_q && rd_data_s1.id == key_id)
			hit_side_q <= rd_data_s1.side;
	end

	assign live_orders = count_q;
endmodule
`default_nettype wire

// File: tb/lobm_checker.sv
// Checker: watches the order and result channels, predicts the book and compares.
`timescale 1ns / 1ps
`default_nettype none
module lobm_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic [2:0]                      opcode,
	input  wire logic [lobm_pkg::ID_BITS-1:0]    order_id,
	input  wire logic                            side,
	input  wire logic [lobm_pkg::PRICE_BITS-1:0] price,
	input  wire logic [lobm_pkg::QTY_BITS-1:0]   quantity,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [2:0]                      kind,
	input  wire logic [lobm_pkg::ID_BITS-1:0]    result_id,
	input  wire logic [lobm_pkg::ID_BITS-1:0]    buy_id,
	input  wire logic [lobm_pkg::ID_BITS-1:0]    sell_id,
	input  wire logic [lobm_pkg::PRICE_BITS-1:0] fill_price,
	input  wire logic [lobm_pkg::QTY_BITS-1:0]   fill_quantity,
	input  wire logic [lobm_pkg::COUNT_BITS-1:0] live_orders,
	input  wire logic                            last,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [30:0]                     cfg_data,
	output int                                   errors,
	output int                                   awaited
);
	import lobm_pkg::*;

	typedef struct {
		logic [2:0]            kind;
		bit [ID_BITS-1:0]      rid;
		bit [ID_BITS-1:0]      bid;
		bit [ID_BITS-1:0]      sid;
		bit [PRICE_BITS-1:0]   fp;
		bit [QTY_BITS-1:0]     fq;
		bit [COUNT_BITS-1:0]   live;
		bit                    lst;
	} book_result_t;

	book_result_t awaited_results[$];

	bit [ID_BITS-1:0]    base_id;
	bit [COUNT_BITS-1:0] init_count;
	bit                  slot_live[ORDER_SLOTS];
	bit                  slot_sd[ORDER_SLOTS];
	bit [PRICE_BITS-1:0] slot_pr[ORDER_SLOTS];
	bit [QTY_BITS-1:0]   slot_qty[ORDER_SLOTS];
	bit [ID_BITS-1:0]    slot_oid[ORDER_SLOTS];
	bit [31:0]           slot_arr[ORDER_SLOTS];
	bit [31:0]           arrivals;
	bit [ID_BITS-1:0]    id_counter;
	bit [COUNT_BITS-1:0] live_count;

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic push_result(input logic [2:0] k, input bit [ID_BITS-1:0] rid,
			input bit [ID_BITS-1:0] bid, input bit [ID_BITS-1:0] sid,
			input bit [PRICE_BITS-1:0] fp, input bit [QTY_BITS-1:0] fq);
		book_result_t r;
		r = '{k, rid, bid, sid, fp, fq, live_count, 1'b0};
		awaited_results.insert(awaited_results.size(), r);
	endtask

	function automatic int find_order(input bit [ID_BITS-1:0] id);
		for (int i = 0; i < ORDER_SLOTS; i++)
			if (slot_live[i] && slot_oid[i] == id)
				return i;
		return -1;
	endfunction

	function automatic int find_free();
		for (int i = 0; i < ORDER_SLOTS; i++)
			if (!slot_live[i])
				return i;
		return -1;
	endfunction

	// sell side wants lowest price, buy side highest; oldest wins a tie
	function automatic int best_order(input bit sd);
		int best;
		bit [PRICE_BITS-1:0] bp;
		bit [31:0] ba, age;
		best = -1;
		bp = '0;
		ba = '0;
		for (int i = 0; i < ORDER_SLOTS; i++) begin
			if (!slot_live[i] || slot_sd[i] != sd)
				continue;
			age = arrivals - slot_arr[i];
			if (best < 0 || (sd ? slot_pr[i] < bp : slot_pr[i] > bp) ||
					(slot_pr[i] == bp && age > ba)) begin
				best = i;
				bp = slot_pr[i];
				ba = age;
			end
		end
		return best;
	endfunction

	task automatic place(input int s, input bit [ID_BITS-1:0] id, input bit sd,
			input bit [PRICE_BITS-1:0] pr, input bit [QTY_BITS-1:0] qty);
		slot_live[s] = 1'b1;
		slot_sd[s] = sd;
		slot_pr[s] = pr;
		slot_qty[s] = qty;
		slot_oid[s] = id;
		slot_arr[s] = arrivals;
		arrivals++;
	endtask

	task automatic retire(input int s);
		slot_live[s] = 1'b0;
		if (live_count != 0)
			live_count--;
	endtask

	task automatic book_step(input logic [2:0] op, input bit [ID_BITS-1:0] oid,
			input bit sd, input bit [PRICE_BITS-1:0] pr, input bit [QTY_BITS-1:0] qty);
		int s, a, b, n;
		bit [ID_BITS-1:0] id, bid, sid;
		bit [QTY_BITS-1:0] q;
		bit [PRICE_BITS-1:0] ap;
		case (op)
			OP_ADD_NEW, OP_ADD_GIVEN: begin
				id = (op == OP_ADD_NEW) ? id_counter + 1'b1 : oid;
				s = find_order(id);
				if (s < 0)
					s = find_free();
				if (s < 0) begin
					push_result(K_FULL, (op == OP_ADD_GIVEN) ? oid : '0, 0, 0, 0, 0);
				end else begin
					if (op == OP_ADD_NEW) begin
						id_counter = id;
						if (live_count != '1)
							live_count++;
					end
					place(s, id, sd, pr, qty);
					push_result(K_ACCEPTED, id, 0, 0, 0, 0);
				end
			end
			OP_CANCEL, OP_MODIFY: begin
				s = find_order(oid);
				if (s < 0) begin
					push_result(K_NOT_FOUND, oid, 0, 0, 0, 0);
				end else if (op == OP_CANCEL) begin
					retire(s);
					push_result(K_ACCEPTED, oid, 0, 0, 0, 0);
				end else begin
					place(s, oid, slot_sd[s], pr, qty);
					push_result(K_ACCEPTED, oid, 0, 0, 0, 0);
				end
			end
			OP_MATCH: begin
				n = 0;
				while (n < MAX_FILLS) begin
					a = best_order(1'b1);
					b = best_order(1'b0);
					if (a < 0 || b < 0 || slot_pr[b] < slot_pr[a])
						break;
					q = slot_qty[a] < slot_qty[b] ? slot_qty[a] : slot_qty[b];
					slot_qty[a] -= q;
					slot_qty[b] -= q;
					bid = slot_oid[b];
					sid = slot_oid[a];
					ap = slot_pr[a];
					if (slot_qty[b] == 0)
						retire(b);
					if (slot_qty[a] == 0)
						retire(a);
					push_result(K_FILL, 0, bid, sid, ap, q);
					n++;
				end
				if (n == 0)
					push_result(K_NO_CROSS, 0, 0, 0, 0, 0);
			end
			default: return;
		endcase
		awaited_results[awaited_results.size() - 1].lst = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		book_result_t w;
		if (!arst_n) begin
			errors = 0;
			awaited_results.delete();
			base_id = '0;
			init_count = '0;
			for (int i = 0; i < ORDER_SLOTS; i++)
				slot_live[i] = 1'b0;
			arrivals = '0;
			id_counter = '0;
			live_count = '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_BASE_ID) begin
					base_id = cfg_data;
					id_counter = base_id;
				end else begin
					init_count = cfg_data[COUNT_BITS-1:0];
					live_count = init_count;
				end
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report("unawaited beat", 1, 0);
				end else begin
					w = awaited_results.pop_front();
					if (kind !== w.kind) report("kind", kind, w.kind);
					if (result_id !== w.rid) report("result_id", result_id, w.rid);
					if (buy_id !== w.bid) report("buy_id", buy_id, w.bid);
					if (sell_id !== w.sid) report("sell_id", sell_id, w.sid);
					if (fill_price !== w.fp) report("fill_price", fill_price, w.fp);
					if (fill_quantity !== w.fq)
						report("fill_quantity", fill_quantity, w.fq);
					if (live_orders !== w.live) report("live_orders", live_orders, w.live);
					if (last !== w.lst) report("last", last, w.lst);
				end
			end
			if (in_valid && in_ready)
				book_step(opcode, order_id, side, price, quantity);
		end
		awaited = awaited_results.size();
	end
endmodule
`default_nettype wire

// File: tb/tb_limit_order_book_matcher_top.sv
// Testbench top: order stimulus, configuration phases, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_limit_order_book_matcher_top;
	import lobm_pkg::*;

	localparam logic [2:0] OP_RESERVED = 3'd7;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic [2:0] opcode;
	logic [ID_BITS-1:0] order_id;
	logic side;
	logic [PRICE_BITS-1:0] price;
	logic [QTY_BITS-1:0] quantity;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic [ID_BITS-1:0] result_id, buy_id, sell_id;
	logic [PRICE_BITS-1:0] fill_price;
	logic [QTY_BITS-1:0] fill_quantity;
	logic [COUNT_BITS-1:0] live_orders;
	logic last;
	logic cfg_we, cfg_index;
	logic [30:0] cfg_data;
	int errors, awaited;
	int idle_pct, stall_pct, add_bias;
	int quiet = 0;

	limit_order_book_matcher_top dut (.*);
	lobm_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("tb_limit_order_book_matcher_top: done, errors");
			$finish;
		end
	end

	task automatic send_order(input logic [2:0] op, input logic [ID_BITS-1:0] id,
			input logic sd, input logic [PRICE_BITS-1:0] pr, input logic [QTY_BITS-1:0] qty);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		order_id <= id;
		side <= sd;
		price <= pr;
		quantity <= qty;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_order();
		int pick;
		logic [2:0] op;
		logic [ID_BITS-1:0] id;
		logic [PRICE_BITS-1:0] pr;
		logic [QTY_BITS-1:0] qty;
		pick = $urandom_range(99);
		if (pick < add_bias / 2)
			op = OP_ADD_NEW;
		else if (pick < add_bias)
			op = OP_ADD_GIVEN;
		else if (pick < add_bias + (100 - add_bias) / 4)
			op = OP_CANCEL;
		else if (pick < add_bias + (100 - add_bias) / 2)
			op = OP_MODIFY;
		else if (pick < 97)
			op = OP_MATCH;
		else
			op = OP_RESERVED - 3'($urandom_range(2));
		id = ($urandom_range(9) == 0) ? ID_BITS'($urandom) : ID_BITS'($urandom_range(40));
		pr = ($urandom_range(9) == 0) ? PRICE_BITS'($urandom) :
			PRICE_BITS'(1000 + $urandom_range(12));
		case ($urandom_range(19))
			0: qty = '0;
			1: qty = '1;
			2: qty = QTY_BITS'($urandom);
			default: qty = QTY_BITS'($urandom_range(1, 30));
		endcase
		send_order(op, id, 1'($urandom_range(1)), pr, qty);
	endtask

	initial begin
		int counts[4];
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_MATCH;
		order_id = '0;
		side = 1'b0;
		price = '0;
		quantity = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE_ID;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		add_bias = 50;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: id wrap, count saturation, extremes, every operation
		write_reg(CFG_BASE_ID, 31'h7FFF_FFFE);
		write_reg(CFG_INIT_COUNT, 31'd126);
		send_order(OP_MATCH, '0, 1'b0, '0, '0);
		send_order(OP_ADD_NEW, '0, 1'b0, '1, '1);
		send_order(OP_ADD_NEW, '1, 1'b1, '0, '1);
		send_order(OP_ADD_NEW, '0, 1'b1, 16'd500, 31'd10);
		send_order(OP_ADD_GIVEN, '1, 1'b0, 16'd400, 31'd5);
		send_order(OP_ADD_GIVEN, '1, 1'b1, 16'd300, 31'd7);
		send_order(OP_CANCEL, 31'h1234_5678, 1'b0, '0, '0);
		send_order(OP_MODIFY, 31'h2AAA_AAAA, 1'b1, '1, '1);
		send_order(OP_MODIFY, '0, 1'b0, 16'd200, 31'd3);
		send_order(OP_ADD_GIVEN, 31'd77, 1'b0, 16'd300, 31'd0);
		send_order(OP_MATCH, '1, 1'b1, '1, '1);
		send_order(OP_ADD_GIVEN, 31'd5, 1'b1, 16'd100, 31'd4);
		send_order(OP_ADD_GIVEN, 31'd6, 1'b0, 16'd100, 31'd4);
		send_order(OP_RESERVED, '1, 1'b1, '1, '1);
		send_order(OP_MATCH, '0, 1'b0, '0, '0);
		send_order(OP_CANCEL, '1, 1'b0, '0, '0);
		send_order(OP_CANCEL, 31'd1, 1'b0, '0, '0);
		send_order(OP_MATCH, '0, 1'b0, '0, '0);
		settle();

		// zero floor of the live count
		write_reg(CFG_INIT_COUNT, 31'd0);
		send_order(OP_CANCEL, 31'h7FFF_FFFF, 1'b0, '0, '0);
		send_order(OP_CANCEL, 31'd0, 1'b0, '0, '0);
		settle();

		counts = '{0, 64, 127, 3};
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 80; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 80; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			write_reg(CFG_BASE_ID, (ph == 2) ? 31'h7FFF_FFF0 : 31'($urandom_range(20)));
			write_reg(CFG_INIT_COUNT, 31'(counts[ph]));
			// first stretch fills the book hard so it runs full
			add_bias = 95;
			for (int i = 0; i < 70; i++)
				random_order();
			add_bias = 55;
			for (int i = 0; i < 55; i++)
				random_order();
			settle();
		end
		idle_pct = 0;
		stall_pct = 0;

		if (errors == 0)
			$display("tb_limit_order_book_matcher_top: done, clean");
		else
			$display("tb_limit_order_book_matcher_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
design/lobm_pkg.sv
design/limit_order_book_matcher_top.sv
tb/lobm_checker.sv
tb/tb_limit_order_book_matcher_top.sv
